// ----- design/ratp_pkg.sv -----
package ratp_pkg;

  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_ADD  = 2'd1;
  localparam logic [1:0] MODE_DEL  = 2'd2;
  localparam logic [1:0] MODE_NOP  = 2'd3;

  localparam logic [1:0] REG_CARRIER_STEP  = 2'd0;
  localparam logic [1:0] REG_ACTIVE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_TOTAL_WIDTH   = 2'd2;
  localparam logic [1:0] REG_ACTIVE_HEIGHT = 2'd3;

  localparam logic [31:0] RST_CARRIER_STEP  = 32'd51717919;
  localparam logic [11:0] RST_ACTIVE_WIDTH  = 12'd1280;
  localparam logic [12:0] RST_TOTAL_WIDTH   = 13'd1688;
  localparam logic [11:0] RST_ACTIVE_HEIGHT = 12'd1024;

  localparam logic [15:0] ONE_Q14 = 16'd16384;
  localparam logic [9:0]  CARRIER_GAIN = 10'd765;

  typedef struct packed {
    logic [31:0] carrier_step;
    logic [11:0] active_width;
    logic [12:0] total_width;
    logic [11:0] active_height;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic add;
    logic idx_clr;
    logic idx_inc;
    logic shift;
    logic dec;
    logic restart;
    logic adv;
    logic carr;
    logic mul;
    logic emit;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       idx_end;
    logic       match;
    logic       shift_end;
    logic       active;
    logic       out_free;
  } sts_t;

endpackage

// ----- design/ratp_regs.sv -----
module ratp_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output ratp_pkg::cfg_t      cfg
);
  import ratp_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.carrier_step  <= RST_CARRIER_STEP;
      cfg_r.active_width  <= RST_ACTIVE_WIDTH;
      cfg_r.total_width   <= RST_TOTAL_WIDTH;
      cfg_r.active_height <= RST_ACTIVE_HEIGHT;
    end else if (wr_en) begin
      case (reg_idx)
        REG_CARRIER_STEP:  cfg_r.carrier_step  <= pwdata;
        REG_ACTIVE_WIDTH:  cfg_r.active_width  <= pwdata[11:0];
        REG_TOTAL_WIDTH:   cfg_r.total_width   <= pwdata[12:0];
        REG_ACTIVE_HEIGHT: cfg_r.active_height <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CARRIER_STEP:  prdata = cfg_r.carrier_step;
      REG_ACTIVE_WIDTH:  prdata = {20'd0, cfg_r.active_width};
      REG_TOTAL_WIDTH:   prdata = {19'd0, cfg_r.total_width};
      REG_ACTIVE_HEIGHT: prdata = {20'd0, cfg_r.active_height};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

// ----- design/ratp_ctrl.sv -----
module ratp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ratp_pkg::sts_t sts,
  output ratp_pkg::cmd_t cmd
);
  import ratp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SEARCH, S_SHIFT, S_ADV, S_CARR, S_MUL, S_EMIT, S_FIN
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          cmd.idx_clr = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.mode)
          MODE_TICK: state_nxt = S_ADV;
          MODE_ADD: begin
            cmd.add = 1'b1;
            cmd.restart = 1'b1;
            state_nxt = S_IDLE;
          end
          MODE_DEL: state_nxt = S_SEARCH;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_SEARCH: begin
        if (sts.idx_end) begin
          cmd.restart = 1'b1;
          state_nxt = S_IDLE;
        end else if (sts.match) begin
          state_nxt = S_SHIFT;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_SHIFT: begin
        if (sts.shift_end) begin
          cmd.dec = 1'b1;
          cmd.restart = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.shift = 1'b1;
          cmd.idx_inc = 1'b1;
        end
      end
      S_ADV: begin
        if (sts.idx_end) begin
          cmd.idx_clr = 1'b1;
          state_nxt = sts.active ? S_CARR : S_FIN;
        end else begin
          cmd.adv = 1'b1;
          cmd.idx_inc = 1'b1;
        end
      end
      S_CARR: begin
        cmd.carr = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (sts.idx_end) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.mul = 1'b1;
          cmd.idx_inc = 1'b1;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- design/ratp_dp.sv -----
module ratp_dp #(
  parameter int MAX_TONES      = 8,
  parameter int COS_TABLE_BITS = 10
) (
  input  logic           clk,
  input  logic           rst_n,
  input  ratp_pkg::cfg_t cfg,
  input  ratp_pkg::cmd_t cmd,
  output ratp_pkg::sts_t sts,
  input  logic [1:0]     in_mode,
  input  logic [31:0]    in_step,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [23:0]    out_data,
  output logic           out_last,
  output logic           out_user
);
  import ratp_pkg::*;

  localparam int CW    = $clog2(MAX_TONES + 1);
  localparam int IW    = (MAX_TONES > 1) ? $clog2(MAX_TONES) : 1;
  localparam int SW    = 9 + MAX_TONES;
  localparam int COS_N = 1 << COS_TABLE_BITS;
  localparam int COS_Q = COS_N / 4;
  localparam int JW    = COS_TABLE_BITS - 1;

  typedef logic [15:0] qtab_t [COS_Q + 1];

  function automatic qtab_t build_qtab();
    qtab_t             t;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint            acc;
    for (int j = 0; j <= COS_Q; j++) begin
      if (j == 0) begin
        t[j] = 16'd16384;
      end else if (j >= COS_Q) begin
        t[j] = 16'd0;
      end else begin
        x    = (64'd3373259426 * 64'(j)) / 64'(2 * COS_Q);
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        acc  = longint'(term);
        for (int n = 0; n < 12; n++) begin
          term = ((term * x2) >> 30) / 64'((2 * n + 1) * (2 * n + 2));
          if (n % 2 == 1) acc = acc + longint'(term);
          else            acc = acc - longint'(term);
        end
        if (acc < 0) acc = 0;
        t[j] = 16'((longint'(acc) + 64'd32768) >> 16);
      end
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  function automatic logic signed [15:0] cos_lu(input logic [31:0] phase);
    logic [COS_TABLE_BITS-1:0] k;
    logic [1:0]                q;
    logic [JW-1:0]             r;
    logic [JW-1:0]             j;
    logic [15:0]               v;
    k = phase[31 -: COS_TABLE_BITS];
    q = k[COS_TABLE_BITS-1 -: 2];
    r = {1'b0, k[COS_TABLE_BITS-3:0]};
    j = q[0] ? (JW'(COS_Q) - r) : r;
    v = QTAB[j];
    return (q[1] ^ q[0]) ? -$signed(v) : $signed(v);
  endfunction

  logic [1:0]   mode_r;
  logic [31:0]  step_r;
  logic [CW-1:0] idx_r;
  logic [CW-1:0] count_r;
  logic [31:0]  steps_r  [MAX_TONES];
  logic [31:0]  phase_r  [MAX_TONES];
  logic [15:0]  factor_r [MAX_TONES];
  logic [12:0]  column_r;
  logic [11:0]  row_r;
  logic [31:0]  carrier_r;
  logic [SW-1:0] s_r;
  logic         out_valid_r;
  logic [23:0]  out_data_r;
  logic         out_last_r;
  logic         out_user_r;

  logic [IW-1:0] ix;
  logic [IW-1:0] ix_next;
  logic [CW:0]   idx_plus;
  logic [11:0]   aw;
  logic [11:0]   ah;
  logic [12:0]   tw;
  logic [13:0]   col_inc;
  logic [12:0]   row_inc;
  logic          frame_end;
  logic signed [16:0] cos_car;
  logic signed [16:0] cos_tone;
  logic [15:0]   u_car;
  logic [15:0]   fac_new;
  logic [25:0]   car_prod;
  logic [SW+15:0] mul_prod;
  logic [7:0]    red;
  logic [7:0]    blue;
  logic [7:0]    green;
  logic [SW-1:0] rem1;
  logic [SW-1:0] rem2;

  assign ix       = idx_r[IW-1:0];
  assign idx_plus = {1'b0, idx_r} + 1'b1;
  assign ix_next  = idx_plus[IW-1:0];
  assign aw       = (cfg.active_width == 12'd0) ? 12'd1 : cfg.active_width;
  assign ah       = (cfg.active_height == 12'd0) ? 12'd1 : cfg.active_height;
  assign tw       = (cfg.total_width < {1'b0, aw}) ? {1'b0, aw} : cfg.total_width;
  assign col_inc  = {1'b0, column_r} + 1'b1;
  assign row_inc  = {1'b0, row_r} + 1'b1;
  assign frame_end = (col_inc >= {1'b0, tw}) && (row_inc >= {1'b0, ah});

  assign cos_car  = 17'(cos_lu(carrier_r));
  assign cos_tone = 17'(cos_lu(phase_r[ix]));
  assign u_car    = 16'($signed({1'b0, ONE_Q14}) + cos_car);
  assign fac_new  = 16'($signed({1'b0, ONE_Q14}) - cos_tone);
  assign car_prod = 26'(CARRIER_GAIN) * 26'(u_car);
  assign mul_prod = (SW+16)'(s_r) * (SW+16)'(factor_r[ix]);

  assign red   = (s_r >= SW'(255)) ? 8'd255 : s_r[7:0];
  assign rem1  = s_r - SW'(red);
  assign blue  = (rem1 >= SW'(255)) ? 8'd255 : rem1[7:0];
  assign rem2  = rem1 - SW'(blue);
  assign green = (rem2 >= SW'(255)) ? 8'd255 : rem2[7:0];

  assign sts.mode      = mode_r;
  assign sts.idx_end   = (idx_r == count_r);
  assign sts.match     = (steps_r[ix] == step_r);
  assign sts.shift_end = (idx_plus >= {1'b0, count_r});
  assign sts.active    = (column_r < {1'b0, aw});
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;
  assign out_user  = out_user_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r <= in_mode;
      step_r <= in_step;
    end
    if (cmd.add && (count_r < CW'(MAX_TONES))) steps_r[count_r[IW-1:0]] <= step_r;
    if (cmd.shift) steps_r[ix] <= steps_r[ix_next];
    if (cmd.adv && (column_r == 13'd0)) factor_r[ix] <= fac_new;
    if (cmd.carr) s_r <= SW'(car_prod >> 16);
    if (cmd.mul) s_r <= SW'(mul_prod >> 14);
    if (cmd.emit) begin
      out_data_r <= {blue, green, red};
      out_last_r <= (column_r == {1'b0, aw - 12'd1});
      out_user_r <= (column_r == 13'd0) && (row_r == 12'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      count_r     <= '0;
      column_r    <= '0;
      row_r       <= '0;
      carrier_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_TONES; i++) phase_r[i] <= '0;
    end else begin
      if (cmd.idx_clr) idx_r <= '0;
      else if (cmd.idx_inc) idx_r <= idx_plus[CW-1:0];

      if (cmd.add && (count_r < CW'(MAX_TONES))) count_r <= idx_plus[CW-1:0] - idx_r + count_r;
      else if (cmd.dec) count_r <= count_r - 1'b1;

      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;

      if (cmd.restart || (cmd.fin && frame_end)) begin
        column_r  <= '0;
        row_r     <= '0;
        carrier_r <= '0;
        for (int i = 0; i < MAX_TONES; i++) phase_r[i] <= '0;
      end else begin
        if (cmd.adv) phase_r[ix] <= phase_r[ix] + steps_r[ix];
        if (cmd.fin) begin
          carrier_r <= carrier_r + cfg.carrier_step;
          if (col_inc >= {1'b0, tw}) begin
            column_r <= '0;
            row_r    <= row_inc[11:0];
          end else begin
            column_r <= col_inc[12:0];
          end
        end
      end
    end
  end

endmodule

// ----- design/raster_am_tone_pattern.sv -----
// a pixel tick is worked by the single phase/factor unit, which walks the tone list once to
// advance the phases and, for an active pixel, once more to multiply; it waits if out stalls
// add and unused mode go back to idle after decode; remove searches, then shifts
// one item at a time: the next transfer is taken only once the last item is through
// reset (synchronous, rst_n low): position, phases, tone count, out valid cleared, config to defaults
module raster_am_tone_pattern #(
  parameter int MAX_TONES      = 8,
  parameter int COS_TABLE_BITS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // tone_step
  input  logic [1:0]  in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // blue, green, red (msb first)
  output logic        out_tlast,  // line_end
  output logic        out_tuser,  // frame_start
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ratp_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  assign cfg_pready = 1'b1;

  ratp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  ratp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ratp_dp #(
    .MAX_TONES      (MAX_TONES),
    .COS_TABLE_BITS (COS_TABLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .in_mode   (in_tuser),
    .in_step   (in_tdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast),
    .out_user  (out_tuser)
  );

endmodule

// ----- design/ratp_checker.sv -----
module ratp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  a_rst_no_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_blue_needs_red: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[23:16] != 8'd0) |-> out_tdata[7:0] == 8'hFF)
    else $error("blue without full red");

  a_green_needs_blue: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[15:8] != 8'd0) |-> out_tdata[23:16] == 8'hFF)
    else $error("green without full blue");

endmodule

bind raster_am_tone_pattern ratp_checker u_ratp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
